// ----- hw/rtl/fbsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Frustum cull package
// Shared types, codes and widths for the box/sphere frustum culling block.
// ----------------------------------------------------------------------------
package fbsc_pkg;

    localparam int NUM_PLANES_DEF = 5;
    localparam int MASK_W         = 5;
    localparam int IDX_W          = 3;
    localparam int OP_W           = 2;
    localparam int VAL_W          = 32;
    localparam int FRAC_W         = 16;
    localparam int PROD_W         = 2 * VAL_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int THR_W          = VAL_W + 1 + FRAC_W;
    localparam int IN_DATA_W      = IDX_W + MASK_W + 6 * VAL_W;
    localparam int OUT_DATA_W     = 8;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_BOX    = 2'd1;
    localparam logic [OP_W-1:0] OP_SPHERE = 2'd2;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LOAD   = 2'd0;
    localparam t_kind KIND_BOX    = 2'd1;
    localparam t_kind KIND_SPHERE = 2'd2;
    localparam t_kind KIND_PASS   = 2'd3;

    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         plane_index;
        logic [MASK_W-1:0]        clip_mask;
        logic signed [VAL_W-1:0]  x_lo;
        logic signed [VAL_W-1:0]  y_lo;
        logic signed [VAL_W-1:0]  z_lo;
        logic signed [VAL_W-1:0]  x_hi;
        logic signed [VAL_W-1:0]  y_hi;
        logic signed [VAL_W-1:0]  z_hi;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage

// ----- hw/rtl/frustum_box_sphere_cull.sv -----
// ----------------------------------------------------------------------------
// Frustum box/sphere cull
// Plane store with box and sphere culling tests against enabled planes.
// Test: one plane per cycle through the back end's multiply, sum and compare
//   stages; loads and passes skip the plane loop.
// The back end takes the next queued word only once the last result is registered.
// Input words queue two deep, so the front accepts while a test runs.
// Synchronous active-low reset clears queue, planes and the disable bit.
// ----------------------------------------------------------------------------
module frustum_box_sphere_cull
    import fbsc_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // plane_index, clip_mask, x_lo, y_lo, z_lo, x_hi, y_hi, z_hi
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // op
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // culled, then zero fill
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    t_qhead w_head;
    logic   w_pop;

    fbsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .i_pop       (w_pop),
        .o_head      (w_head)
    );

    fbsc_back #(
        .NUM_PLANES (NUM_PLANES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- hw/rtl/fbsc_front.sv -----
// ----------------------------------------------------------------------------
// Frustum cull front end
// Accepts input words, classifies them by op and disable, queues two deep.
// ----------------------------------------------------------------------------
module fbsc_front
    import fbsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  i_pop,
    output t_qhead                o_head
);

    logic       r_disable;
    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.plane_index = s_tdata[IDX_W-1:0];
        w_cmd.clip_mask   = s_tdata[IDX_W +: MASK_W];
        w_cmd.x_lo        = s_tdata[IDX_W + MASK_W + 0*VAL_W +: VAL_W];
        w_cmd.y_lo        = s_tdata[IDX_W + MASK_W + 1*VAL_W +: VAL_W];
        w_cmd.z_lo        = s_tdata[IDX_W + MASK_W + 2*VAL_W +: VAL_W];
        w_cmd.x_hi        = s_tdata[IDX_W + MASK_W + 3*VAL_W +: VAL_W];
        w_cmd.y_hi        = s_tdata[IDX_W + MASK_W + 4*VAL_W +: VAL_W];
        w_cmd.z_hi        = s_tdata[IDX_W + MASK_W + 5*VAL_W +: VAL_W];
        unique case (s_tuser)
            OP_LOAD:   w_cmd.kind = KIND_LOAD;
            OP_BOX:    w_cmd.kind = r_disable ? KIND_PASS : KIND_BOX;
            OP_SPHERE: w_cmd.kind = r_disable ? KIND_PASS : KIND_SPHERE;
            default:   w_cmd.kind = KIND_PASS;
        endcase
    end

    assign s_tready = (r_cnt != 2'd2);
    assign w_push   = s_tvalid && s_tready;
    assign w_pop    = i_pop && (r_cnt != 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disable <= 1'b0;
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_cnt     <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_disable <= i_cfg_wdata;
            end
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_mem[r_rp];

endmodule

// ----- hw/rtl/fbsc_back.sv -----
// ----------------------------------------------------------------------------
// Frustum cull back end
// Holds the plane store, runs loads and plane-serial box/sphere tests.
// ----------------------------------------------------------------------------
module fbsc_back
    import fbsc_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_qhead                 i_head,
    output logic                   o_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    localparam int NTEST = (NUM_PLANES < MASK_W) ? NUM_PLANES : MASK_W;
    localparam int PW    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam logic [PW-1:0] P_LAST = PW'(NTEST - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]              r_state;
    t_cmd                    r_cmd;
    logic [PW-1:0]           r_p;
    logic                    r_acc;
    logic                    r_out_valid;
    logic                    r_out_culled;

    logic signed [VAL_W-1:0] r_nx   [NUM_PLANES];
    logic signed [VAL_W-1:0] r_ny   [NUM_PLANES];
    logic signed [VAL_W-1:0] r_nz   [NUM_PLANES];
    logic signed [VAL_W-1:0] r_dist [NUM_PLANES];
    logic [2:0]              r_sign [NUM_PLANES];

    logic                    r_occ1;
    logic                    r_v1;
    logic                    r_box1;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_py;
    logic signed [PROD_W-1:0] r_pz;
    logic signed [THR_W-1:0] r_thr1;

    logic                    r_occ2;
    logic                    r_v2;
    logic                    r_box2;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [THR_W-1:0] r_thr2;

    logic                    w_issue;
    logic                    w_en;
    logic signed [VAL_W-1:0] w_ox;
    logic signed [VAL_W-1:0] w_oy;
    logic signed [VAL_W-1:0] w_oz;
    logic [2:0]              w_s;
    logic signed [THR_W-1:0] w_thr;
    logic signed [SUM_W-1:0] w_thr_x;
    logic                    w_hit;
    logic                    w_out_free;
    logic                    w_finish;
    logic                    w_load;

    assign w_out_free = !r_out_valid || m_tready;
    assign o_pop      = (r_state == S_IDLE) && i_head.valid;
    assign w_load     = o_pop && (i_head.cmd.kind == KIND_LOAD);
    assign w_issue    = (r_state == S_RUN);
    assign w_finish   = (r_state == S_FIN) && !r_occ1 && !r_occ2 && w_out_free;

    always_comb begin
        w_s  = r_sign[r_p];
        w_en = r_cmd.clip_mask[r_p];
        if (r_cmd.kind == KIND_BOX) begin
            w_ox  = w_s[0] ? r_cmd.x_lo : r_cmd.x_hi;
            w_oy  = w_s[1] ? r_cmd.y_lo : r_cmd.y_hi;
            w_oz  = w_s[2] ? r_cmd.z_lo : r_cmd.z_hi;
            w_thr = THR_W'(r_dist[r_p]) <<< FRAC_W;
        end else begin
            w_ox  = r_cmd.x_lo;
            w_oy  = r_cmd.y_lo;
            w_oz  = r_cmd.z_lo;
            w_thr = (THR_W'(r_dist[r_p]) - THR_W'(r_cmd.x_hi)) <<< FRAC_W;
        end
    end

    assign w_thr_x = SUM_W'(r_thr2);
    assign w_hit   = r_v2 && (r_box2 ? (r_sum < w_thr_x) : (r_sum <= w_thr_x));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_p          <= '0;
            r_acc        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_occ1       <= 1'b0;
            r_occ2       <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            for (int i = 0; i < NUM_PLANES; i++) begin
                r_nx[i]   <= '0;
                r_ny[i]   <= '0;
                r_nz[i]   <= '0;
                r_dist[i] <= '0;
                r_sign[i] <= '0;
            end
        end else begin
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_occ1 <= w_issue;
            r_v1   <= w_issue && w_en;
            r_occ2 <= r_occ1;
            r_v2   <= r_v1;
            if (o_pop) begin
                r_acc <= 1'b0;
            end else if (w_hit) begin
                r_acc <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_p   <= '0;
                        if (i_head.cmd.kind == KIND_BOX || i_head.cmd.kind == KIND_SPHERE) begin
                            r_state <= S_RUN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_RUN: begin
                    if (r_p == P_LAST) begin
                        r_state <= S_FIN;
                    end else begin
                        r_p <= r_p + PW'(1);
                    end
                end
                S_FIN: begin
                    if (w_finish) begin
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_load) begin
                for (int i = 0; i < NUM_PLANES; i++) begin
                    if (i_head.cmd.plane_index == IDX_W'(i)) begin
                        r_nx[i]   <= i_head.cmd.x_lo;
                        r_ny[i]   <= i_head.cmd.y_lo;
                        r_nz[i]   <= i_head.cmd.z_lo;
                        r_dist[i] <= i_head.cmd.x_hi;
                        r_sign[i] <= {i_head.cmd.z_lo[VAL_W-1], i_head.cmd.y_lo[VAL_W-1],
                                      i_head.cmd.x_lo[VAL_W-1]};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head.cmd;
        end
        if (w_finish) begin
            r_out_culled <= r_acc;
        end
        r_box1 <= (r_cmd.kind == KIND_BOX);
        r_px   <= PROD_W'(r_nx[r_p]) * PROD_W'(w_ox);
        r_py   <= PROD_W'(r_ny[r_p]) * PROD_W'(w_oy);
        r_pz   <= PROD_W'(r_nz[r_p]) * PROD_W'(w_oz);
        r_thr1 <= w_thr;
        r_box2 <= r_box1;
        r_sum  <= SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz);
        r_thr2 <= r_thr1;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, r_out_culled};

endmodule

// ----- tb/sv/frustum_box_sphere_cull_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frustum cull checker
// Watches the input and result streams of the frustum cull block, keeps its
// own plane store and disable bit, predicts the culled flag of every accepted
// word and compares it against the result stream in order.
// ----------------------------------------------------------------------------
module frustum_box_sphere_cull_checker
    import fbsc_pkg::*;
#(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // plane_index, clip_mask, x_lo, y_lo, z_lo, x_hi, y_hi, z_hi
    input  logic [IN_DATA_W-1:0]   i_s_tdata,
    // op
    input  logic [OP_W-1:0]        i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // culled, then zero fill
    input  logic [OUT_DATA_W-1:0]  i_m_tdata,
    output int                     o_pending,
    output int                     o_fail_count
);

    localparam int VAL_LSB = IDX_W + MASK_W;

    typedef struct {
        logic             culled;
        int unsigned      seq;
        logic [OP_W-1:0]  op;
    } t_cull_expect;

    logic signed [VAL_W-1:0] norm_x     [NUM_PLANES];
    logic signed [VAL_W-1:0] norm_y     [NUM_PLANES];
    logic signed [VAL_W-1:0] norm_z     [NUM_PLANES];
    logic signed [VAL_W-1:0] plane_dist [NUM_PLANES];
    logic [2:0]              neg_signs  [NUM_PLANES];
    logic                    cull_off;

    t_cull_expect            pending_culls [$];
    t_cull_expect            oldest;
    t_cull_expect            fresh;
    int unsigned             word_seq;
    int                      mismatches = 0;

    logic [OP_W-1:0]         in_op;
    logic [IDX_W-1:0]        in_idx;
    logic [MASK_W-1:0]       in_mask;
    logic signed [VAL_W-1:0] in_xl, in_yl, in_zl, in_xh, in_yh, in_zh;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic signed [SUM_W-1:0] plane_dot(
        input int p,
        input logic signed [VAL_W-1:0] x,
        input logic signed [VAL_W-1:0] y,
        input logic signed [VAL_W-1:0] z
    );
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] acc;
        a = SUM_W'(norm_x[p]);
        b = SUM_W'(x);
        acc = a * b;
        a = SUM_W'(norm_y[p]);
        b = SUM_W'(y);
        acc = acc + a * b;
        a = SUM_W'(norm_z[p]);
        b = SUM_W'(z);
        acc = acc + a * b;
        return acc;
    endfunction

    function automatic logic predict_culled(
        input logic [OP_W-1:0]        op,
        input logic [MASK_W-1:0]      mask,
        input logic signed [VAL_W-1:0] xl,
        input logic signed [VAL_W-1:0] yl,
        input logic signed [VAL_W-1:0] zl,
        input logic signed [VAL_W-1:0] xh,
        input logic signed [VAL_W-1:0] yh,
        input logic signed [VAL_W-1:0] zh
    );
        logic signed [SUM_W-1:0] dot;
        logic signed [SUM_W-1:0] thr;
        logic signed [SUM_W-1:0] dist_w;
        logic signed [SUM_W-1:0] rad_w;
        logic signed [VAL_W-1:0] cx, cy, cz;
        logic                    hit;
        int                      p;
        hit = 1'b0;
        if (cull_off || (op != OP_BOX && op != OP_SPHERE)) begin
            return 1'b0;
        end
        for (p = 0; p < NUM_PLANES && p < MASK_W; p++) begin
            if (mask[p]) begin
                dist_w = SUM_W'(plane_dist[p]);
                if (op == OP_BOX) begin
                    // take the corner farthest along the normal
                    cx = neg_signs[p][0] ? xl : xh;
                    cy = neg_signs[p][1] ? yl : yh;
                    cz = neg_signs[p][2] ? zl : zh;
                    dot = plane_dot(p, cx, cy, cz);
                    thr = dist_w <<< FRAC_W;
                    if (dot < thr) begin
                        hit = 1'b1;
                    end
                end else begin
                    rad_w = SUM_W'(xh);
                    dot = plane_dot(p, xl, yl, zl);
                    thr = (dist_w - rad_w) <<< FRAC_W;
                    if (dot <= thr) begin
                        hit = 1'b1;
                    end
                end
            end
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                norm_x[p]     = '0;
                norm_y[p]     = '0;
                norm_z[p]     = '0;
                plane_dist[p] = '0;
                neg_signs[p]  = '0;
            end
            cull_off = 1'b0;
            pending_culls.delete();
            word_seq = 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                cull_off = i_cfg_wdata;
            end

            if (i_m_tvalid && i_m_tready) begin
                if (pending_culls.size() == 0) begin
                    report_mismatch($sformatf("result word 0x%02h with no test pending",
                                              i_m_tdata));
                end else begin
                    oldest = pending_culls.pop_front();
                    if (i_m_tdata[0] !== oldest.culled) begin
                        report_mismatch($sformatf("word %0d op %0d: culled %b, predicted %b",
                                                  oldest.seq, oldest.op, i_m_tdata[0],
                                                  oldest.culled));
                    end
                    if (i_m_tdata[OUT_DATA_W-1:1] !== '0) begin
                        report_mismatch($sformatf("word %0d: fill bits 0x%02h not zero",
                                                  oldest.seq, i_m_tdata));
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                in_op   = i_s_tuser;
                in_idx  = i_s_tdata[0 +: IDX_W];
                in_mask = i_s_tdata[IDX_W +: MASK_W];
                in_xl   = i_s_tdata[VAL_LSB + 0 * VAL_W +: VAL_W];
                in_yl   = i_s_tdata[VAL_LSB + 1 * VAL_W +: VAL_W];
                in_zl   = i_s_tdata[VAL_LSB + 2 * VAL_W +: VAL_W];
                in_xh   = i_s_tdata[VAL_LSB + 3 * VAL_W +: VAL_W];
                in_yh   = i_s_tdata[VAL_LSB + 4 * VAL_W +: VAL_W];
                in_zh   = i_s_tdata[VAL_LSB + 5 * VAL_W +: VAL_W];

                fresh.culled = predict_culled(in_op, in_mask, in_xl, in_yl, in_zl,
                                              in_xh, in_yh, in_zh);
                fresh.seq    = word_seq;
                fresh.op     = in_op;
                pending_culls.push_back(fresh);
                word_seq++;

                if (in_op == OP_LOAD && in_idx < NUM_PLANES) begin
                    norm_x[in_idx]     = in_xl;
                    norm_y[in_idx]     = in_yl;
                    norm_z[in_idx]     = in_zl;
                    plane_dist[in_idx] = in_xh;
                    neg_signs[in_idx]  = {in_zl < 0, in_yl < 0, in_xl < 0};
                end
            end

            o_pending <= pending_culls.size();
        end
    end

endmodule

// ----- tb/sv/frustum_box_sphere_cull_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frustum cull testbench
// Drives plane loads, box and sphere tests through the frustum cull block:
// a directed set of edge cases, then random phases under both disable
// settings with random idling on both streams and one long result stall.
// The checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module frustum_box_sphere_cull_test;
    import fbsc_pkg::*;

    localparam int NUM_PLANES  = NUM_PLANES_DEF;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT     = 150;
    localparam int STALL_LIMIT = 2000;

    localparam logic signed [VAL_W-1:0] ONE   = 32'sh0001_0000;
    localparam logic signed [VAL_W-1:0] MIN_Q = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] MAX_Q = 32'sh7fff_ffff;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [OP_W-1:0]        s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;

    int                     pending;
    int                     fail_count;
    bit                     steady = 1'b0;
    int                     stall_cycles = 0;
    int                     words_taken = 0;
    bit                     held_off = 1'b0;

    always #6 i_clk = ~i_clk;

    frustum_box_sphere_cull #(
        .NUM_PLANES (NUM_PLANES)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    frustum_box_sphere_cull_checker #(
        .NUM_PLANES (NUM_PLANES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic logic signed [VAL_W-1:0] span_q(input int half);
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_q();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 5))
                    0: return MIN_Q;
                    1: return MAX_Q;
                    2: return 0;
                    3: return -1;
                    4: return ONE;
                    default: return -ONE;
                endcase
            end
            default: return span_q(16 * ONE);
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_normal();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return pick_q();
            default: return span_q(ONE);
        endcase
    endfunction

    task automatic send_word(
        input logic [OP_W-1:0]        op,
        input logic [IDX_W-1:0]       idx,
        input logic [MASK_W-1:0]      mask,
        input logic signed [VAL_W-1:0] xl,
        input logic signed [VAL_W-1:0] yl,
        input logic signed [VAL_W-1:0] zl,
        input logic signed [VAL_W-1:0] xh,
        input logic signed [VAL_W-1:0] yh,
        input logic signed [VAL_W-1:0] zh
    );
        s_tdata  <= {zh, yh, xh, zl, yl, xl, mask, idx};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        if (!steady && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(output bit counted);
        logic signed [VAL_W-1:0] a [3];
        logic signed [VAL_W-1:0] b [3];
        logic [IDX_W-1:0]        idx;
        logic [MASK_W-1:0]       mask;
        int                      r;
        r = $urandom_range(0, 99);
        mask = ($urandom_range(0, 2) == 0) ? 5'($urandom) : '1;
        for (int k = 0; k < 3; k++) begin
            a[k] = pick_q();
            b[k] = pick_q();
        end
        counted = 1'b1;
        if (r < 18) begin
            idx = ($urandom_range(0, 9) != 0) ? IDX_W'($urandom_range(0, NUM_PLANES - 1))
                                               : IDX_W'($urandom_range(NUM_PLANES, 7));
            counted = (idx < NUM_PLANES);
            send_word(OP_LOAD, idx, 5'($urandom), pick_normal(), pick_normal(),
                      pick_normal(), pick_q(), $urandom, $urandom);
        end else if (r < 58) begin
            // keep most boxes well ordered, leave some inverted
            if ($urandom_range(0, 99) < 85) begin
                for (int k = 0; k < 3; k++) begin
                    if (a[k] > b[k]) begin
                        {a[k], b[k]} = {b[k], a[k]};
                    end
                end
            end
            send_word(OP_BOX, 3'($urandom), mask, a[0], a[1], a[2], b[0], b[1], b[2]);
        end else if (r < 95) begin
            b[0] = ($urandom_range(0, 4) != 0) ? int'($urandom_range(0, 8 * ONE)) : pick_q();
            send_word(OP_SPHERE, 3'($urandom), mask, a[0], a[1], a[2], b[0],
                      $urandom, $urandom);
        end else begin
            counted = 1'b0;
            send_word(KIND_PASS, 3'($urandom), 5'($urandom), $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic run_random(input int count);
        int sent;
        bit counted;
        sent = 0;
        while (sent < count) begin
            send_random(counted);
            sent += counted;
        end
    endtask

    task automatic drain_and_set_disable(input logic value);
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_LOAD;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store
        send_word(OP_BOX, 0, 5'h1f, -ONE, -ONE, -ONE, ONE, ONE, ONE);
        send_word(OP_SPHERE, 0, 5'h1f, ONE, ONE, ONE, 0, 0, 0);
        send_word(OP_SPHERE, 7, 5'h00, ONE, 0, 0, -ONE, 0, 0);
        // load planes, then out-of-range indexes and the unused op
        send_word(OP_LOAD, 0, 0, ONE, 0, 0, 0, 0, 0);
        send_word(OP_LOAD, 1, 0, -ONE, 0, 0, -10 * ONE, 0, 0);
        send_word(OP_LOAD, 2, 5'h1f, 0, -ONE, -ONE, -100 * ONE, 0, 0);
        send_word(OP_LOAD, 3, 0, MIN_Q, MAX_Q, -1, MAX_Q, MAX_Q, MIN_Q);
        send_word(OP_LOAD, 4, 0, 0, 0, ONE, MIN_Q, 0, 0);
        send_word(OP_LOAD, 5, 5'h1f, ONE, ONE, ONE, MAX_Q, 0, 0);
        send_word(OP_LOAD, 7, 5'h1f, -ONE, -ONE, -ONE, MAX_Q, 0, 0);
        send_word(KIND_PASS, 2, 5'h1f, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
        // boxes: outside, touching, inverted, extremes
        send_word(OP_BOX, 0, 5'h01, -2 * ONE, 0, 0, -ONE, 0, 0);
        send_word(OP_BOX, 0, 5'h01, -ONE, 0, 0, 0, 0, 0);
        send_word(OP_BOX, 0, 5'h02, 11 * ONE, 0, 0, 12 * ONE, 0, 0);
        send_word(OP_BOX, 0, 5'h02, 10 * ONE, 0, 0, 12 * ONE, 0, 0);
        send_word(OP_BOX, 0, 5'h01, ONE, 0, 0, -2 * ONE, 0, 0);
        send_word(OP_BOX, 0, 5'h04, 0, 60 * ONE, 50 * ONE, ONE, 70 * ONE, 60 * ONE);
        send_word(OP_BOX, 0, 5'h1f, MIN_Q, MIN_Q, MIN_Q, MAX_Q, MAX_Q, MAX_Q);
        send_word(OP_BOX, 0, 5'h08, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q);
        // spheres: touching, just inside, negative radius, extremes
        send_word(OP_SPHERE, 0, 5'h01, -ONE, 0, 0, ONE, 0, 0);
        send_word(OP_SPHERE, 0, 5'h01, -ONE, 0, 0, ONE + 1, 0, 0);
        send_word(OP_SPHERE, 0, 5'h01, ONE, 0, 0, -2 * ONE, 0, 0);
        send_word(OP_SPHERE, 0, 5'h1f, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MAX_Q);
        send_word(OP_SPHERE, 0, 5'h10, 0, 0, -5 * ONE, ONE, 0, 0);
        send_word(OP_SPHERE, 0, 5'h08, MIN_Q, MAX_Q, 0, MAX_Q, 0, 0);

        drain_and_set_disable(1'b1);
        run_random(40);
        drain_and_set_disable(1'b0);
        steady = 1'b1;
        run_random(90);
        steady = 1'b0;
        run_random(80);
        drain_and_set_disable(1'b1);
        run_random(30);
        drain_and_set_disable(1'b0);
        run_random(160);

        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (NUM_PLANES + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // result side: random back-pressure, one long hold-off
    initial begin
        m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                words_taken++;
            end
            if (!held_off && words_taken >= HOLD_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
hw/rtl/fbsc_pkg.sv
hw/rtl/fbsc_front.sv
hw/rtl/fbsc_back.sv
hw/rtl/frustum_box_sphere_cull.sv
tb/sv/frustum_box_sphere_cull_checker.sv
tb/sv/frustum_box_sphere_cull_test.sv
